### hw/rtl/btlv_pkg.sv
`default_nettype none
package btlv_pkg;

    localparam int MAX_DEPTH_DEF     = 4;
    localparam int MAX_OID_BYTES_DEF = 128;
    localparam int MAX_INT_BYTES_DEF = 8;
    localparam int MAX_LEN_BYTES_DEF = 4;
    localparam int RESULT_LIMIT      = 6;

    typedef enum logic [1:0] {
        PH_TAG       = 2'd0,
        PH_LEN_FIRST = 2'd1,
        PH_LEN_MORE  = 2'd2,
        PH_CONTENT   = 2'd3
    } phase_t;

    typedef enum logic [2:0] {
        CL_BAD   = 3'd0,
        CL_SEQ   = 3'd1,
        CL_INT   = 3'd2,
        CL_UNS   = 3'd3,
        CL_NULL  = 3'd4,
        CL_STR   = 3'd5,
        CL_OID   = 3'd6,
        CL_UNSUP = 3'd7
    } class_t;

    localparam logic [3:0] K_SEQ_OPEN  = 4'd0;
    localparam logic [3:0] K_INTEGER   = 4'd1;
    localparam logic [3:0] K_UNSIGNED  = 4'd2;
    localparam logic [3:0] K_NULL      = 4'd3;
    localparam logic [3:0] K_STR_HEAD  = 4'd4;
    localparam logic [3:0] K_STR_BYTE  = 4'd5;
    localparam logic [3:0] K_OID_ARC   = 4'd6;
    localparam logic [3:0] K_SEQ_CLOSE = 4'd7;
    localparam logic [3:0] K_ERROR     = 4'd8;

    localparam logic [3:0] E_NONE       = 4'd0;
    localparam logic [3:0] E_BAD_TAG    = 4'd1;
    localparam logic [3:0] E_INDEF      = 4'd2;
    localparam logic [3:0] E_LEN_LONG   = 4'd3;
    localparam logic [3:0] E_OVERRUN    = 4'd4;
    localparam logic [3:0] E_INT_LONG   = 4'd5;
    localparam logic [3:0] E_OID_LONG   = 4'd6;
    localparam logic [3:0] E_NULL_LEN   = 4'd7;
    localparam logic [3:0] E_TRUNC      = 4'd8;
    localparam logic [3:0] E_UNSUP      = 4'd9;
    localparam logic [3:0] E_TOO_DEEP   = 4'd10;

    // one token as it travels between the parser, the queue and the output
    typedef struct packed {
        logic [3:0]  kind;
        logic [7:0]  tag;
        logic [63:0] value;
        logic [2:0]  depth;
        logic        last_of_item;
        logic [3:0]  error_code;
    } token_t;

    // parsed octet event handed from front to back
    typedef struct packed {
        logic [3:0]  kind;        // K_ERROR means error token
        logic [7:0]  tag;
        logic [63:0] value;
        logic [3:0]  error_code;
        logic        emit;        // primary token present
        logic        oid_split;   // primary is a first-arc pair: value/40, value%40
        logic        trunc;       // append truncation error
        logic [2:0]  depth;       // depth for primary token
        logic [3:0]  n_close;     // closes following the primary
        logic [7:0]  close_tags_0;
        logic [7:0]  close_tags_1;
        logic [7:0]  close_tags_2;
        logic [7:0]  close_tags_3;
        logic [7:0]  close_tags_4;
        logic [7:0]  close_tags_5;
        logic [7:0]  trunc_tag;
    } event_t;

    function automatic class_t classify(input logic [7:0] t);
        class_t c;
        c = CL_BAD;
        if (t == 8'h30 || (t >= 8'hA0 && t <= 8'hA8)) c = CL_SEQ;
        else begin
            case (t)
                8'h02:                      c = CL_INT;
                8'h41, 8'h42, 8'h43, 8'h47: c = CL_UNS;
                8'h05, 8'h80, 8'h81, 8'h82: c = CL_NULL;
                8'h04, 8'h03, 8'h40, 8'h45: c = CL_STR;
                8'h06:                      c = CL_OID;
                8'h44, 8'h46, 8'h48, 8'h49, 8'h4A, 8'h4B, 8'h9F: c = CL_UNSUP;
                default:                    c = CL_BAD;
            endcase
        end
        return c;
    endfunction

endpackage
`default_nettype wire

### hw/rtl/ber_tlv_stream_decoder_unit.sv
`default_nettype none
// ber tlv stream decoder
// input queue side: each push transaction carries one octet with
// data_byte/start_req/last while full is low; start_req clears the parser
// before its octet is taken, last marks the final octet so that any open
// element is reported as truncated
// output queue side: tokens (kind, tag, value, depth, last_of_item,
// error_code) wait while empty is low; pop takes the oldest one
// one octet is parsed per cycle in the front part while full is low; it yields
// one event that the back part expands into 0..6 tokens, one token per cycle
// while the output queue has room; the event of an accepted octet is
// registered in the back part and its first token is then written into the
// output queue, whose head drives the result ports; throughput: one octet per
// cycle while each octet gives at most one token and the queue has room; an
// octet with more tokens holds full high while the back part expands its event
// when the receiver stalls, tokens pile in the output queue, then the
// back part holds, then full rises and input stops
// reset clears the parser, the event stage and the queue; the sequence end
// stack needs no clearing since it is only read below the open count
module ber_tlv_stream_decoder_unit
    import btlv_pkg::*;
#(
    parameter int MAX_DEPTH     = MAX_DEPTH_DEF,
    parameter int MAX_OID_BYTES = MAX_OID_BYTES_DEF,
    parameter int MAX_INT_BYTES = MAX_INT_BYTES_DEF,
    parameter int MAX_LEN_BYTES = MAX_LEN_BYTES_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  data_byte,
    input  wire logic        start_req,
    input  wire logic        last,
    output logic             empty,
    input  wire logic        pop,
    output logic [3:0]       kind,
    output logic [7:0]       tag,
    output logic signed [63:0] value,
    output logic [2:0]       depth,
    output logic             last_of_item,
    output logic [3:0]       error_code
);

    event_t ev;
    logic   ev_valid, ev_ready;
    token_t tok, qout;
    logic   tok_valid, q_full;

    // front waits while the back part still expands an event
    assign full = !ev_ready;

    btlv_front #(
        .MAX_DEPTH(MAX_DEPTH), .MAX_OID_BYTES(MAX_OID_BYTES),
        .MAX_INT_BYTES(MAX_INT_BYTES), .MAX_LEN_BYTES(MAX_LEN_BYTES)
    ) u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(push && ev_ready),
        .data_byte(data_byte), .start_req(start_req), .last(last),
        .ev(ev), .ev_valid(ev_valid)
    );

    btlv_back u_back (
        .clk(clk), .rst_n(rst_n), .ev_valid(ev_valid && push), .ev(ev),
        .ev_ready(ev_ready), .tok_valid(tok_valid), .tok(tok),
        .tok_ready(!q_full)
    );

    btlv_fifo #(.DEPTH(RESULT_LIMIT)) u_fifo (
        .clk(clk), .rst_n(rst_n), .wr(tok_valid), .din(tok), .full(q_full),
        .rd(pop), .dout(qout), .empty(empty)
    );

    assign kind         = qout.kind;
    assign tag          = qout.tag;
    assign value        = qout.value;
    assign depth        = qout.depth;
    assign last_of_item = qout.last_of_item;
    assign error_code   = qout.error_code;

endmodule
`default_nettype wire

### hw/rtl/btlv_front.sv
`default_nettype none
module btlv_front
    import btlv_pkg::*;
#(
    parameter int MAX_DEPTH     = MAX_DEPTH_DEF,
    parameter int MAX_OID_BYTES = MAX_OID_BYTES_DEF,
    parameter int MAX_INT_BYTES = MAX_INT_BYTES_DEF,
    parameter int MAX_LEN_BYTES = MAX_LEN_BYTES_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire logic [7:0] data_byte,
    input  wire logic       start_req,
    input  wire logic       last,
    output event_t          ev,
    output logic            ev_valid
);

    localparam int DW = $clog2(MAX_DEPTH + 1);
    localparam int SW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

    phase_t        phase_reg, phase_next;
    logic [7:0]    tag_reg, tag_next;
    logic [31:0]   lacc_reg, lacc_next;
    logic [2:0]    lleft_reg, lleft_next;
    logic [31:0]   cleft_reg, cleft_next;
    logic [63:0]   vacc_reg, vacc_next;
    logic          first_reg, first_next;
    logic [31:0]   pos_reg, pos_next;
    logic [DW-1:0] open_reg, open_next;
    logic          err_reg, err_next;
    logic [31:0]   ends_reg [MAX_DEPTH];
    logic [7:0]    stags_reg [MAX_DEPTH];
    logic          push_w;
    logic [SW-1:0] push_idx;
    logic [31:0]   push_end;

    // working copies of the state after start_req clearing
    phase_t        ph;
    logic [31:0]   lacc, cleft, pos;
    logic [DW-1:0] oc;
    logic          er;
    logic [31:0]   top_end;
    logic [32:0]   end_pos;
    class_t        cl;
    logic          do_complete;
    logic [63:0]   v;
    logic [31:0]   hlen;
    logic          hdr;
    logic [3:0]    ncl;
    logic [DW-1:0] oc_c;
    logic [7:0]    ctags [6];

    always_comb
    begin
        phase_next = phase_reg; tag_next = tag_reg; lacc_next = lacc_reg;
        lleft_next = lleft_reg; cleft_next = cleft_reg; vacc_next = vacc_reg;
        first_next = first_reg; pos_next = pos_reg; open_next = open_reg;
        err_next = err_reg;
        push_w = 1'b0; push_idx = '0; push_end = '0;
        ev = '0; ev_valid = 1'b0;
        do_complete = 1'b0; hdr = 1'b0; hlen = '0; end_pos = '0;
        v = '0; ncl = '0; oc_c = '0;
        for (int i = 0; i < 6; i++) ctags[i] = '0;

        ph = phase_reg; lacc = lacc_reg; cleft = cleft_reg; pos = pos_reg;
        oc = open_reg; er = err_reg;
        if (start_req) begin
            ph = PH_TAG; lacc = '0; cleft = '0; pos = '0; oc = '0; er = 1'b0;
            tag_next = '0; lleft_next = '0; vacc_next = '0; first_next = 1'b0;
        end
        phase_next = ph; lacc_next = lacc; cleft_next = cleft; pos_next = pos;
        open_next = oc; err_next = er;
        top_end = (oc != '0) ? ends_reg[SW'(oc - 1'b1)] : '0;
        cl = classify(start_req ? 8'h00 : tag_reg);

        if (in_valid && !er) begin
            ev_valid = 1'b1;
            ev.tag = start_req ? 8'h00 : tag_reg;
            ev.depth = 3'(oc);
            if ((ph == PH_LEN_FIRST || ph == PH_LEN_MORE) && oc != '0 && pos >= top_end) begin
                ev.emit = 1'b1; ev.kind = K_ERROR; ev.error_code = E_OVERRUN;
                err_next = 1'b1;
            end else begin
                pos_next = pos + 32'd1;
                case (ph)
                    PH_TAG:
                    begin
                        tag_next = data_byte;
                        ev.tag = data_byte;
                        cl = classify(data_byte);
                        if (cl == CL_BAD) begin
                            ev.emit = 1'b1; ev.kind = K_ERROR; ev.error_code = E_BAD_TAG;
                            err_next = 1'b1;
                        end else if (cl == CL_UNSUP) begin
                            ev.emit = 1'b1; ev.kind = K_ERROR; ev.error_code = E_UNSUP;
                            err_next = 1'b1;
                        end else phase_next = PH_LEN_FIRST;
                    end
                    PH_LEN_FIRST:
                    begin
                        if (data_byte < 8'h80) begin
                            hdr = 1'b1; hlen = {24'd0, data_byte};
                        end else if (data_byte == 8'h80) begin
                            ev.emit = 1'b1; ev.kind = K_ERROR; ev.error_code = E_INDEF;
                            err_next = 1'b1;
                        end else if (32'(data_byte[6:0]) > 32'(MAX_LEN_BYTES)) begin
                            ev.emit = 1'b1; ev.kind = K_ERROR; ev.error_code = E_LEN_LONG;
                            err_next = 1'b1;
                        end else begin
                            lacc_next = '0;
                            lleft_next = data_byte[2:0];
                            phase_next = PH_LEN_MORE;
                        end
                    end
                    PH_LEN_MORE:
                    begin
                        lacc_next = {lacc[23:0], data_byte};
                        lleft_next = lleft_reg - 3'd1;
                        if (lleft_reg == 3'd1) begin
                            hdr = 1'b1; hlen = {lacc[23:0], data_byte};
                        end
                    end
                    default:
                    begin
                        if (cl == CL_INT || cl == CL_UNS) begin
                            v = vacc_reg;
                            if (cl == CL_INT && cleft == lacc && data_byte[7]) v = '1;
                            v = {v[55:0], data_byte};
                            vacc_next = v;
                            cleft_next = cleft - 32'd1;
                            if (cleft == 32'd1) begin
                                ev.emit = 1'b1;
                                ev.kind = (cl == CL_INT) ? K_INTEGER : K_UNSIGNED;
                                ev.value = v;
                                do_complete = 1'b1;
                            end
                        end else if (cl == CL_STR) begin
                            ev.emit = 1'b1; ev.kind = K_STR_BYTE;
                            ev.value = {56'd0, data_byte};
                            cleft_next = cleft - 32'd1;
                            if (cleft == 32'd1) do_complete = 1'b1;
                        end else if (cl == CL_OID) begin
                            cleft_next = cleft - 32'd1;
                            if (vacc_reg > 64'h01FF_FFFF) begin
                                ev.emit = 1'b1; ev.kind = K_ERROR; ev.error_code = E_OID_LONG;
                                err_next = 1'b1;
                            end else begin
                                v = {vacc_reg[56:0], data_byte[6:0]};
                                vacc_next = v;
                                if (!data_byte[7]) begin
                                    ev.emit = 1'b1; ev.kind = K_OID_ARC; ev.value = v;
                                    ev.oid_split = first_reg;
                                    first_next = 1'b0;
                                    vacc_next = '0;
                                end
                                if (cleft == 32'd1) begin
                                    if (data_byte[7]) begin
                                        ev.emit = 1'b1; ev.kind = K_ERROR;
                                        ev.error_code = E_TRUNC;
                                        ev.value = '0;
                                        err_next = 1'b1;
                                    end else do_complete = 1'b1;
                                end
                            end
                        end else do_complete = 1'b1;
                    end
                endcase

                if (hdr) begin
                    end_pos = {1'b0, pos + 32'd1} + {1'b0, hlen};
                    cl = classify(tag_reg);
                    if ((oc != '0 && end_pos > {1'b0, top_end}) || end_pos[32]) begin
                        ev.emit = 1'b1; ev.kind = K_ERROR; ev.error_code = E_OVERRUN;
                        err_next = 1'b1;
                    end else begin
                        cleft_next = hlen; lacc_next = hlen; vacc_next = '0;
                        ev.value = {32'd0, hlen};
                        case (cl)
                            CL_SEQ:
                            begin
                                if (32'(oc) >= 32'(MAX_DEPTH)) begin
                                    ev.emit = 1'b1; ev.kind = K_ERROR; ev.value = '0;
                                    ev.error_code = E_TOO_DEEP; err_next = 1'b1;
                                end else begin
                                    ev.emit = 1'b1; ev.kind = K_SEQ_OPEN;
                                    push_w = 1'b1; push_idx = SW'(oc);
                                    push_end = end_pos[31:0];
                                    phase_next = PH_TAG;
                                    do_complete = 1'b1;
                                end
                            end
                            CL_INT, CL_UNS:
                            begin
                                if (hlen > 32'(MAX_INT_BYTES)) begin
                                    ev.emit = 1'b1; ev.kind = K_ERROR; ev.value = '0;
                                    ev.error_code = E_INT_LONG; err_next = 1'b1;
                                end else if (hlen == '0) begin
                                    ev.emit = 1'b1;
                                    ev.kind = (cl == CL_INT) ? K_INTEGER : K_UNSIGNED;
                                    do_complete = 1'b1;
                                end else phase_next = PH_CONTENT;
                            end
                            CL_NULL:
                            begin
                                ev.emit = 1'b1; ev.value = '0;
                                if (hlen != '0) begin
                                    ev.kind = K_ERROR; ev.error_code = E_NULL_LEN;
                                    err_next = 1'b1;
                                end else begin
                                    ev.kind = K_NULL; do_complete = 1'b1;
                                end
                            end
                            CL_STR:
                            begin
                                ev.emit = 1'b1; ev.kind = K_STR_HEAD;
                                if (hlen == '0) do_complete = 1'b1;
                                else phase_next = PH_CONTENT;
                            end
                            CL_OID:
                            begin
                                if ({1'b0, hlen} + 33'd1 > 33'(MAX_OID_BYTES)) begin
                                    ev.emit = 1'b1; ev.kind = K_ERROR; ev.value = '0;
                                    ev.error_code = E_OID_LONG; err_next = 1'b1;
                                end else if (hlen == '0) begin
                                    ev.emit = 1'b1; ev.kind = K_OID_ARC;
                                    ev.oid_split = 1'b1; do_complete = 1'b1;
                                end else begin
                                    first_next = 1'b1; phase_next = PH_CONTENT;
                                end
                            end
                            default:
                            begin
                                ev.emit = 1'b1; ev.kind = K_ERROR; ev.value = '0;
                                ev.error_code = E_BAD_TAG; err_next = 1'b1;
                            end
                        endcase
                    end
                end

                // pop every sequence ending here, bounded by the stack depth
                if (do_complete) begin
                    phase_next = PH_TAG;
                    oc_c = push_w ? DW'(oc + 1'b1) : oc;
                    for (int i = MAX_DEPTH - 1; i >= 0; i--) begin
                        if (i < 32'(oc_c) && 32'(ncl) == 32'(oc_c) - 1 - i) begin
                            if ((push_w && i == 32'(oc)) ? (push_end == pos + 32'd1)
                                    : (ends_reg[i] == pos + 32'd1)) begin
                                if (ncl < 4'd6)
                                    ctags[ncl[2:0]] = (push_w && i == 32'(oc))
                                        ? tag_reg : stags_reg[i];
                                ncl = ncl + 4'd1;
                            end
                        end
                    end
                    open_next = DW'(oc_c - DW'(ncl));
                    ev.n_close = ncl;
                end
            end

            if (!err_next && last && (phase_next != PH_TAG || open_next != '0)) begin
                ev.trunc = 1'b1; ev.trunc_tag = tag_next; err_next = 1'b1;
            end
            ev.close_tags_0 = ctags[0]; ev.close_tags_1 = ctags[1];
            ev.close_tags_2 = ctags[2]; ev.close_tags_3 = ctags[3];
            ev.close_tags_4 = ctags[4]; ev.close_tags_5 = ctags[5];
            if (!ev.emit && ev.n_close == '0 && !ev.trunc) ev_valid = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg <= PH_TAG; tag_reg <= '0; lacc_reg <= '0; lleft_reg <= '0;
            cleft_reg <= '0; vacc_reg <= '0; first_reg <= 1'b0; pos_reg <= '0;
            open_reg <= '0; err_reg <= 1'b0;
        end else if (in_valid) begin
            phase_reg <= phase_next; tag_reg <= tag_next; lacc_reg <= lacc_next;
            lleft_reg <= lleft_next; cleft_reg <= cleft_next; vacc_reg <= vacc_next;
            first_reg <= first_next; pos_reg <= pos_next; open_reg <= open_next;
            err_reg <= err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && push_w) begin
            ends_reg[push_idx]  <= push_end;
            stags_reg[push_idx] <= tag_reg;
        end
    end

endmodule
`default_nettype wire

### hw/rtl/btlv_back.sv
`default_nettype none
module btlv_back
    import btlv_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   ev_valid,
    input  wire event_t ev,
    output logic        ev_ready,
    output logic        tok_valid,
    output token_t      tok,
    input  wire logic   tok_ready
);

    // expands one event into its token list, one token per cycle while tok_ready is high
    event_t     cur_reg;
    logic       busy_reg;
    logic [3:0] idx_reg, idx_next;
    logic [3:0] cnt;
    logic [3:0] n_pri;
    logic [3:0] k;
    logic [7:0] ctag;
    logic [63:0] q40, r40;
    logic [60:0] prod;
    logic [26:0] quo;
    logic [31:0] rem;

    // value/40 for arcs below 2^32: drop three bits, then divide by 5
    // through a reciprocal multiply
    assign prod = 61'(cur_reg.value[31:3]) * 61'h0CCCCCCCD;
    always_comb
    begin
        quo = prod[60:34];
        rem = cur_reg.value[31:0] - {quo, 5'd0} - {2'd0, quo, 3'd0};
        q40 = {37'd0, quo};
        r40 = {58'd0, rem[5:0]};
    end

    always_comb
    begin
        n_pri = cur_reg.emit ? (cur_reg.oid_split ? 4'd2 : 4'd1) : 4'd0;
        cnt = n_pri + ((cur_reg.n_close > 4'd6) ? 4'd6 : cur_reg.n_close)
              + (cur_reg.trunc ? 4'd1 : 4'd0);
        if (cnt > 4'd6) cnt = 4'd6;
        k = idx_reg - n_pri;
        case (k[2:0])
            3'd0: ctag = cur_reg.close_tags_0;
            3'd1: ctag = cur_reg.close_tags_1;
            3'd2: ctag = cur_reg.close_tags_2;
            3'd3: ctag = cur_reg.close_tags_3;
            3'd4: ctag = cur_reg.close_tags_4;
            default: ctag = cur_reg.close_tags_5;
        endcase
        tok = '0;
        if (idx_reg < n_pri) begin
            tok.kind = cur_reg.kind; tok.tag = cur_reg.tag;
            tok.depth = cur_reg.depth; tok.error_code = cur_reg.error_code;
            tok.value = cur_reg.oid_split ? ((idx_reg == 4'd0) ? q40 : r40)
                                          : cur_reg.value;
            if (cur_reg.kind == K_ERROR) tok.value = '0;
        end else if (k < cur_reg.n_close) begin
            tok.kind = K_SEQ_CLOSE; tok.tag = ctag;
            tok.depth = cur_reg.depth + ((cur_reg.kind == K_SEQ_OPEN && cur_reg.emit)
                        ? 3'd1 : 3'd0) - 3'(k) - 3'd1;
        end else begin
            tok.kind = K_ERROR; tok.tag = cur_reg.trunc_tag;
            tok.error_code = E_TRUNC;
            tok.depth = cur_reg.depth + ((cur_reg.kind == K_SEQ_OPEN && cur_reg.emit)
                        ? 3'd1 : 3'd0) - 3'(cur_reg.n_close);
        end
        tok.last_of_item = (idx_reg + 4'd1 == cnt);
        tok_valid = busy_reg;
        ev_ready = !busy_reg || (tok_ready && idx_reg + 4'd1 == cnt);
        idx_next = (tok_valid && tok_ready) ? idx_reg + 4'd1 : idx_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0; idx_reg <= '0;
        end else if (ev_ready) begin
            busy_reg <= ev_valid; idx_reg <= '0;
        end else begin
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ev_ready) cur_reg <= ev;
    end

endmodule
`default_nettype wire

### hw/rtl/btlv_fifo.sv
`default_nettype none
module btlv_fifo
    import btlv_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   wr,
    input  wire token_t din,
    output logic        full,
    input  wire logic   rd,
    output token_t      dout,
    output logic        empty
);
    localparam int AW = $clog2(DEPTH);
    token_t       mem_reg [DEPTH];
    logic [AW-1:0] wp_reg, rp_reg;
    logic [AW:0]   cnt_reg;

    assign full  = (cnt_reg == (AW+1)'(DEPTH));
    assign empty = (cnt_reg == '0);
    assign dout  = mem_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wp_reg <= '0; rp_reg <= '0; cnt_reg <= '0;
        end else begin
            if (wr && !full) wp_reg <= AW'(32'(wp_reg) + 1 == DEPTH ? 0 : 32'(wp_reg) + 1);
            if (rd && !empty) rp_reg <= AW'(32'(rp_reg) + 1 == DEPTH ? 0 : 32'(rp_reg) + 1);
            cnt_reg <= cnt_reg + (AW+1)'(wr && !full) - (AW+1)'(rd && !empty);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr && !full) mem_reg[wp_reg] <= din;
    end
endmodule
`default_nettype wire

### tb/ber_tlv_token_checker.sv
`timescale 1ns / 100ps
module ber_tlv_token_checker
    import btlv_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    input  wire logic        full,
    input  wire logic [7:0]  data_byte,
    input  wire logic        start_req,
    input  wire logic        last,
    input  wire logic        empty,
    input  wire logic        pop,
    input  wire logic [3:0]  kind,
    input  wire logic [7:0]  tag,
    input  wire logic [63:0] value,
    input  wire logic [2:0]  depth,
    input  wire logic        last_of_item,
    input  wire logic [3:0]  error_code,
    output int               fails,
    output int               pending
);

    token_t      expected_tokens[$];
    token_t      octet_tokens[$];
    phase_t      ph;
    logic [7:0]  cur_tag;
    logic [31:0] len_acc;
    logic [2:0]  len_left;
    logic [31:0] cont_left;
    logic [63:0] val_acc;
    logic        first_arc;
    logic [31:0] pos;
    logic [31:0] seq_end[MAX_DEPTH_DEF];
    logic [7:0]  seq_tag[MAX_DEPTH_DEF];
    int          nopen;
    logic        err_lat;

    initial fails = 0;

    function automatic class_t tag_class(input logic [7:0] t);
        if (t == 8'h30 || (t >= 8'hA0 && t <= 8'hA8))
            return CL_SEQ;
        case (t)
            8'h02:                      return CL_INT;
            8'h41, 8'h42, 8'h43, 8'h47: return CL_UNS;
            8'h05, 8'h80, 8'h81, 8'h82: return CL_NULL;
            8'h04, 8'h03, 8'h40, 8'h45: return CL_STR;
            8'h06:                      return CL_OID;
            8'h44, 8'h46, 8'h48, 8'h49, 8'h4A, 8'h4B, 8'h9F: return CL_UNSUP;
            default:                    return CL_BAD;
        endcase
    endfunction

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] exp);
        $display("%0t: token mismatch on %s: got %0h, expected %0h", $realtime, what, got, exp);
        fails++;
    endtask

    task automatic add_token(input logic [3:0] k, input logic [7:0] t,
                             input logic [63:0] v, input logic [3:0] e);
        token_t x;
        x.kind = k;
        x.tag = t;
        x.value = v;
        x.depth = nopen[2:0];
        x.last_of_item = 1'b0;
        x.error_code = e;
        if (octet_tokens.size() < RESULT_LIMIT)
            octet_tokens.push_back(x);
    endtask

    task automatic raise_error(input logic [3:0] code);
        add_token(K_ERROR, cur_tag, 64'd0, code);
        err_lat = 1'b1;
    endtask

    // pop every sequence that ends at the current position
    task automatic element_done();
        ph = PH_TAG;
        while (nopen > 0 && seq_end[nopen-1] == pos)
        begin
            nopen--;
            add_token(K_SEQ_CLOSE, seq_tag[nopen], 64'd0, E_NONE);
        end
    endtask

    task automatic header_done();
        logic [63:0] end_pos;
        logic [63:0] len;
        class_t      c;
        len = {32'd0, len_acc};
        end_pos = {32'd0, pos} + len;
        c = tag_class(cur_tag);
        if ((nopen > 0 && end_pos > {32'd0, seq_end[nopen-1]}) || end_pos > 64'hFFFF_FFFF)
        begin
            raise_error(E_OVERRUN);
            return;
        end
        cont_left = len_acc;
        val_acc = 64'd0;
        case (c)
            CL_SEQ:
            begin
                if (nopen >= MAX_DEPTH_DEF)
                begin
                    raise_error(E_TOO_DEEP);
                    return;
                end
                add_token(K_SEQ_OPEN, cur_tag, len, E_NONE);
                seq_end[nopen] = end_pos[31:0];
                seq_tag[nopen] = cur_tag;
                nopen++;
                element_done();
            end
            CL_INT, CL_UNS:
            begin
                if (len > MAX_INT_BYTES_DEF)
                    raise_error(E_INT_LONG);
                else if (len == 0)
                begin
                    add_token(c == CL_INT ? K_INTEGER : K_UNSIGNED, cur_tag, 64'd0, E_NONE);
                    element_done();
                end
                else
                    ph = PH_CONTENT;
            end
            CL_NULL:
            begin
                if (len != 0)
                    raise_error(E_NULL_LEN);
                else
                begin
                    add_token(K_NULL, cur_tag, 64'd0, E_NONE);
                    element_done();
                end
            end
            CL_STR:
            begin
                add_token(K_STR_HEAD, cur_tag, len, E_NONE);
                if (len == 0)
                    element_done();
                else
                    ph = PH_CONTENT;
            end
            CL_OID:
            begin
                if (len + 1 > MAX_OID_BYTES_DEF)
                    raise_error(E_OID_LONG);
                else if (len == 0)
                begin
                    add_token(K_OID_ARC, cur_tag, 64'd0, E_NONE);
                    add_token(K_OID_ARC, cur_tag, 64'd0, E_NONE);
                    element_done();
                end
                else
                begin
                    first_arc = 1'b1;
                    ph = PH_CONTENT;
                end
            end
            default:
                raise_error(E_BAD_TAG);
        endcase
    endtask

    task automatic content_octet(input logic [7:0] b);
        class_t c;
        c = tag_class(cur_tag);
        if (c == CL_INT || c == CL_UNS)
        begin
            if (c == CL_INT && cont_left == len_acc && b[7])
                val_acc = '1;
            val_acc = {val_acc[55:0], b};
            cont_left--;
            if (cont_left == 0)
            begin
                add_token(c == CL_INT ? K_INTEGER : K_UNSIGNED, cur_tag, val_acc, E_NONE);
                element_done();
            end
        end
        else if (c == CL_STR)
        begin
            add_token(K_STR_BYTE, cur_tag, {56'd0, b}, E_NONE);
            cont_left--;
            if (cont_left == 0)
                element_done();
        end
        else if (c == CL_OID)
        begin
            cont_left--;
            if (val_acc > 64'h01FF_FFFF)
            begin
                raise_error(E_OID_LONG);
                return;
            end
            val_acc = (val_acc << 7) | {57'd0, b[6:0]};
            if (!b[7])
            begin
                // first subidentifier carries two arcs
                if (first_arc)
                begin
                    add_token(K_OID_ARC, cur_tag, val_acc / 40, E_NONE);
                    add_token(K_OID_ARC, cur_tag, val_acc % 40, E_NONE);
                    first_arc = 1'b0;
                end
                else
                    add_token(K_OID_ARC, cur_tag, val_acc, E_NONE);
                val_acc = 64'd0;
            end
            if (cont_left == 0)
            begin
                if (b[7])
                    raise_error(E_TRUNC);
                else
                    element_done();
            end
        end
        else
            element_done();
    endtask

    task automatic clear_parser();
        ph = PH_TAG;
        cur_tag = 8'd0;
        len_acc = 32'd0;
        len_left = 3'd0;
        cont_left = 32'd0;
        val_acc = 64'd0;
        first_arc = 1'b0;
        pos = 32'd0;
        nopen = 0;
        err_lat = 1'b0;
    endtask

    task automatic decode_octet(input logic [7:0] b, input logic st, input logic lst);
        class_t c;
        octet_tokens.delete();
        if (st)
            clear_parser();
        if (err_lat)
            return;
        if ((ph == PH_LEN_FIRST || ph == PH_LEN_MORE) && nopen > 0 && pos >= seq_end[nopen-1])
            raise_error(E_OVERRUN);
        else
        begin
            pos = pos + 1;
            case (ph)
                PH_TAG:
                begin
                    cur_tag = b;
                    c = tag_class(b);
                    if (c == CL_BAD)
                        raise_error(E_BAD_TAG);
                    else if (c == CL_UNSUP)
                        raise_error(E_UNSUP);
                    else
                        ph = PH_LEN_FIRST;
                end
                PH_LEN_FIRST:
                begin
                    if (b < 8'h80)
                    begin
                        len_acc = {24'd0, b};
                        header_done();
                    end
                    else if (b == 8'h80)
                        raise_error(E_INDEF);
                    else if (b[6:0] > MAX_LEN_BYTES_DEF)
                        raise_error(E_LEN_LONG);
                    else
                    begin
                        len_acc = 32'd0;
                        len_left = b[2:0];
                        ph = PH_LEN_MORE;
                    end
                end
                PH_LEN_MORE:
                begin
                    len_acc = {len_acc[23:0], b};
                    len_left = len_left - 3'd1;
                    if (len_left == 0)
                        header_done();
                end
                default:
                    content_octet(b);
            endcase
        end
        if (!err_lat && lst && (ph != PH_TAG || nopen > 0))
            raise_error(E_TRUNC);
        if (octet_tokens.size() > 0)
            octet_tokens[octet_tokens.size()-1].last_of_item = 1'b1;
        foreach (octet_tokens[i])
            expected_tokens.push_back(octet_tokens[i]);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        token_t x;
        if (!rst_n)
        begin
            clear_parser();
            expected_tokens.delete();
            pending <= 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (expected_tokens.size() == 0)
                    report("unexpected token kind", {60'd0, kind}, 64'd0);
                else
                begin
                    x = expected_tokens.pop_front();
                    if (kind != x.kind) report("kind", {60'd0, kind}, {60'd0, x.kind});
                    if (tag != x.tag) report("tag", {56'd0, tag}, {56'd0, x.tag});
                    if (value != x.value) report("value", value, x.value);
                    if (depth != x.depth) report("depth", {61'd0, depth}, {61'd0, x.depth});
                    if (last_of_item != x.last_of_item)
                        report("last_of_item", {63'd0, last_of_item}, {63'd0, x.last_of_item});
                    if (error_code != x.error_code)
                        report("error_code", {60'd0, error_code}, {60'd0, x.error_code});
                end
            end
            if (push && !full)
                decode_octet(data_byte, start_req, last);
            pending <= expected_tokens.size();
        end
    end

endmodule

### tb/tb_ber_tlv_stream_decoder_unit.sv
`timescale 1ns / 100ps
// stimulus and verdict for the ber tlv decoder; the checker beside the
// block predicts and compares every token transaction
module tb_ber_tlv_stream_decoder_unit;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [7:0]  data_byte;
    logic        start_req;
    logic        last;
    logic        empty;
    logic        pop;
    logic [3:0]  kind;
    logic [7:0]  tag;
    logic signed [63:0] value;
    logic [2:0]  depth;
    logic        last_of_item;
    logic [3:0]  error_code;
    int          fails;
    int          pending;

    // stimulus controls; burst and long_hold are shared with the receiver process
    bit          burst;
    bit          long_hold;
    int          octets_sent;
    int          idle_cycles;
    logic [7:0]  msg[$];

    ber_tlv_stream_decoder_unit DUT (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .data_byte(data_byte),
        .start_req(start_req), .last(last), .empty(empty), .pop(pop), .kind(kind),
        .tag(tag), .value(value), .depth(depth), .last_of_item(last_of_item),
        .error_code(error_code)
    );

    ber_tlv_token_checker checker_i (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .data_byte(data_byte),
        .start_req(start_req), .last(last), .empty(empty), .pop(pop), .kind(kind),
        .tag(tag), .value(value), .depth(depth), .last_of_item(last_of_item),
        .error_code(error_code), .fails(fails), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog: too many cycles without any transaction means a hang
    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty))
            idle_cycles <= 0;
        else if (idle_cycles >= 3000)
        begin
            $display("Some tests failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // one octet transaction; push stays high when the next gap is zero
    task automatic send_octet(input logic [7:0] b, input logic st, input logic lst);
        int g;
        g = burst ? 0 : $urandom_range(0, 9);
        if ($urandom_range(0, 3) == 0)
            g = 0;
        if (g > 0)
        begin
            push <= 1'b0;
            repeat (g) @(posedge clk);
        end
        push <= 1'b1;
        data_byte <= b;
        start_req <= st;
        last <= lst;
        do @(posedge clk); while (full);
        octets_sent++;
    endtask

    task automatic send_message(input bit with_last);
        foreach (msg[i])
            send_octet(msg[i], i == 0, with_last && i == msg.size() - 1);
    endtask

    // wait until every predicted token has been popped
    task automatic drain();
        push <= 1'b0;
        repeat (2) @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // length octets, short or long form, sometimes padded with leading zeros
    function automatic void put_length(ref logic [7:0] q[$], input int n);
        int nb;
        if (n < 128 && $urandom_range(0, 3) != 0)
            q.push_back(n[7:0]);
        else
        begin
            nb = $urandom_range(n < 256 ? 1 : 2, 4);
            q.push_back(8'h80 | nb[7:0]);
            for (int i = nb - 1; i >= 0; i--)
                q.push_back(8'((n >> (8 * i)) & 8'hFF));
        end
    endfunction

    // random well formed element, nesting down to one past the stack limit
    function automatic void build_element(input int lvl, ref logic [7:0] q[$]);
        logic [7:0] body[$];
        logic [7:0] t;
        logic [7:0] uns_tags[4];
        logic [7:0] null_tags[4];
        logic [7:0] str_tags[4];
        int         k;
        int         n;
        uns_tags = '{8'h41, 8'h42, 8'h43, 8'h47};
        null_tags = '{8'h05, 8'h80, 8'h81, 8'h82};
        str_tags = '{8'h04, 8'h03, 8'h40, 8'h45};
        k = $urandom_range(0, 9);
        if (lvl == 0 || (k < 3 && lvl < 5))
        begin
            t = $urandom_range(0, 1) ? 8'h30 : 8'hA0 + 8'($urandom_range(0, 8));
            n = $urandom_range(lvl == 0 ? 1 : 0, 3);
            repeat (n) build_element(lvl + 1, body);
        end
        else if (k < 5)
        begin
            t = $urandom_range(0, 1) ? 8'h02 : uns_tags[$urandom_range(0, 3)];
            n = ($urandom_range(0, 14) == 0) ? 9 : $urandom_range(0, 8);
            repeat (n) body.push_back(8'($urandom));
        end
        else if (k < 6)
        begin
            t = null_tags[$urandom_range(0, 3)];
            if ($urandom_range(0, 9) == 0)
                body.push_back(8'($urandom));
        end
        else if (k < 8)
        begin
            t = str_tags[$urandom_range(0, 3)];
            repeat ($urandom_range(0, 6)) body.push_back(8'($urandom));
        end
        else
        begin
            t = 8'h06;
            n = $urandom_range(0, 6);
            for (int i = 0; i < n; i++)
                body.push_back(i == n - 1 && $urandom_range(0, 7) != 0
                               ? 8'($urandom_range(0, 127)) : 8'($urandom));
        end
        q.push_back(t);
        put_length(q, body.size());
        foreach (body[i])
            q.push_back(body[i]);
    endfunction

    // receiver: random pop gaps, plus one long hold that fills the block
    initial
    begin
        int g;
        pop = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (long_hold)
            begin
                pop <= 1'b0;
                repeat (400) @(posedge clk);
                long_hold = 1'b0;
            end
            g = burst ? 0 : $urandom_range(0, 9);
            if ($urandom_range(0, 3) == 0)
                g = 0;
            if (g > 0)
            begin
                pop <= 1'b0;
                repeat (g) @(posedge clk);
            end
            pop <= 1'b1;
            do @(posedge clk); while (empty);
        end
    end

    initial
    begin
        rst_n = 1'b0;
        push = 1'b0;
        data_byte = 8'd0;
        start_req = 1'b0;
        last = 1'b0;
        burst = 1'b0;
        long_hold = 1'b0;
        octets_sent = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: sign extension, extremes, each error and the closing cases
        msg = '{8'h30, 8'h03, 8'h02, 8'h01, 8'h80};                 send_message(1);
        msg = '{8'h02, 8'h08, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
        send_message(1);
        msg = '{8'h43, 8'h84, 8'h00, 8'h00, 8'h00, 8'h01, 8'hFF};   send_message(1);
        msg = '{8'h07};                                             send_message(1);
        msg = '{8'h44};                                             send_message(1);
        msg = '{8'h04, 8'h80};                                      send_message(1);
        msg = '{8'h04, 8'h85};                                      send_message(1);
        msg = '{8'h02, 8'h09};                                      send_message(1);
        msg = '{8'h05, 8'h01};                                      send_message(1);
        msg = '{8'h06, 8'h02, 8'h2B, 8'h86};                        send_message(1);
        msg = '{8'h06, 8'h00, 8'h05, 8'h00};                        send_message(1);
        msg = '{8'h30, 8'h01, 8'h02, 8'h05};                        send_message(1);
        msg = '{8'h30, 8'h01, 8'h04, 8'h00};                        send_message(1);
        msg = '{8'h30, 8'h0A, 8'h30, 8'h08, 8'h30, 8'h06, 8'h30, 8'h04, 8'h30, 8'h02};
        send_message(1);
        // one null closes three sequences at once
        msg = '{8'h30, 8'h06, 8'hA0, 8'h04, 8'h30, 8'h02, 8'h05, 8'h00, 8'h30, 8'h00};
        send_message(1);
        msg = '{8'h06, 8'h06, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h7F}; send_message(1);
        msg = '{8'h06, 8'h81, 8'h80};                               send_message(1);
        msg = '{8'h30, 8'h05, 8'h02};                               send_message(1);
        drain();

        // pressure: receiver holds off while a string keeps coming
        msg = '{8'h04, 8'h18};
        repeat (24) msg.push_back(8'($urandom));
        burst = 1'b1;
        long_hold = 1'b1;
        send_message(1);
        burst = 1'b0;
        drain();

        // random messages, mostly well formed, some corrupted, some noise
        while (octets_sent < 160)
        begin
            msg.delete();
            if ($urandom_range(0, 9) == 0)
            begin
                repeat ($urandom_range(1, 6))
                    send_octet(8'($urandom), 1'($urandom), 1'($urandom));
            end
            else
            begin
                build_element(0, msg);
                if ($urandom_range(0, 7) == 0)
                    msg[$urandom_range(0, msg.size() - 1)] = 8'($urandom);
                if ($urandom_range(0, 9) == 0 && msg.size() > 1)
                    msg = msg[0:$urandom_range(0, msg.size() - 2)];
                burst = ($urandom_range(0, 4) == 0);
                send_message($urandom_range(0, 9) != 0);
                burst = 1'b0;
            end
        end

        drain();
        repeat (20) @(posedge clk);
        if (fails == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
